// ===== rtl/core/circular_deque_core_defines.svh =====
// assertion macros shared by the deque checker
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define CDQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed");

// next-cycle implication, sampled on the rising clock edge
`define CDQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// ===== rtl/core/cdq_pkg.sv =====
// shared types and constants for the circular deque
`default_nettype none

package cdq_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int DATA_W        = 32;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_REAR  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_REAR   = 3'd3,
      KIND_PEEK_FRONT = 3'd4,
      KIND_PEEK_REAR  = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/cdq_ctrl.sv =====
// request sequencer for the circular deque
`default_nettype none

module cdq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output cdq_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ACCESS = 3'b010,
      ST_OUTPUT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.execute = 1'b1;
            state_in    = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUTPUT);

endmodule

`default_nettype wire

// ===== rtl/core/cdq_datapath.sv =====
// index registers, slot memory and result registers of the circular deque
`default_nettype none

module cdq_datapath #(
   parameter int SLOTS = cdq_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cdq_pkg::cmd_type              cmd,
   input  wire logic [cdq_pkg::DATA_W-1:0]    req_tdata,
   input  wire logic [cdq_pkg::KIND_W-1:0]    req_tuser,
   output logic      [cdq_pkg::DATA_W-1:0]    rsp_tdata,
   output logic      [cdq_pkg::STATUS_W-1:0]  rsp_tuser
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [cdq_pkg::DATA_W-1:0] mem [SLOTS];

   logic [IDX_W-1:0]           front_ff;
   logic [IDX_W-1:0]           front_in;
   logic [IDX_W-1:0]           rear_ff;
   logic [IDX_W-1:0]           rear_in;
   cdq_pkg::kind_type          kind_ff;
   logic [cdq_pkg::DATA_W-1:0] word_ff;
   cdq_pkg::status_type        status_ff;
   cdq_pkg::status_type        status_in;
   logic                       hit_ff;
   logic                       hit_in;
   logic [cdq_pkg::DATA_W-1:0] rd_ff;

   logic [IDX_W-1:0]           addr_in;
   logic                       wr_en_in;
   logic [IDX_W-1:0]           front_up;
   logic [IDX_W-1:0]           front_dn;
   logic [IDX_W-1:0]           rear_up;
   logic [IDX_W-1:0]           rear_dn;
   logic                       queue_empty;
   logic                       is_full;

   always_comb begin
      front_up    = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
      front_dn    = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
      rear_up     = (rear_ff == LAST_IDX) ? '0 : rear_ff + IDX_W'(1);
      rear_dn     = (rear_ff == '0) ? LAST_IDX : rear_ff - IDX_W'(1);
      queue_empty = (front_ff == rear_ff);
      is_full     = (rear_up == front_ff);
   end

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      status_in = cdq_pkg::STATUS_OK;
      hit_in    = 1'b0;
      wr_en_in  = 1'b0;
      addr_in   = front_up;
      unique case (kind_ff)
         cdq_pkg::KIND_PUSH_FRONT: begin
            if (is_full) begin
               status_in = cdq_pkg::STATUS_FULL;
            end else begin
               wr_en_in = 1'b1;
               addr_in  = front_ff;
               front_in = front_dn;
            end
         end
         cdq_pkg::KIND_PUSH_REAR: begin
            if (is_full) begin
               status_in = cdq_pkg::STATUS_FULL;
            end else begin
               wr_en_in = 1'b1;
               addr_in  = rear_up;
               rear_in  = rear_up;
            end
         end
         cdq_pkg::KIND_POP_FRONT: begin
            if (queue_empty) begin
               status_in = cdq_pkg::STATUS_EMPTY;
            end else begin
               hit_in   = 1'b1;
               addr_in  = front_up;
               front_in = front_up;
            end
         end
         cdq_pkg::KIND_POP_REAR: begin
            if (queue_empty) begin
               status_in = cdq_pkg::STATUS_EMPTY;
            end else begin
               hit_in  = 1'b1;
               addr_in = rear_ff;
               rear_in = rear_dn;
            end
         end
         cdq_pkg::KIND_PEEK_FRONT: begin
            if (queue_empty) begin
               status_in = cdq_pkg::STATUS_EMPTY;
            end else begin
               hit_in  = 1'b1;
               addr_in = front_up;
            end
         end
         cdq_pkg::KIND_PEEK_REAR: begin
            if (queue_empty) begin
               status_in = cdq_pkg::STATUS_EMPTY;
            end else begin
               hit_in  = 1'b1;
               addr_in = rear_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= cdq_pkg::kind_type'(req_tuser);
         word_ff <= req_tdata;
      end
   end

   // index update
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
      end else if (cmd.execute) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   // slot memory, single port with registered read
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (wr_en_in) begin
            mem[addr_in] <= word_ff;
         end
         rd_ff <= mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
      end
   end

   assign rsp_tdata = hit_ff ? rd_ff : '0;
   assign rsp_tuser = status_ff;

endmodule

`default_nettype wire

// ===== rtl/core/circular_deque_core.sv =====
// Double-ended queue of 32-bit words in a circular store of SLOTS entries, holding at most
// SLOTS-1 words. Each request beat on req (kind in req_tuser, push word in req_tdata) yields
// exactly one response beat on rsp (word in rsp_tdata, status in rsp_tuser). The request is
// captured at its accepting edge, the following cycle updates the indices and does the
// single-port slot memory access with its registered read, and the response is offered from
// the cycle after that; the next request is accepted in the cycle after the response beat is
// taken, so only one request is in flight at a time.
// Pushes into a full queue and pops or peeks on an empty one are refused with zero data and
// no state change; unknown kinds return zero data with ok status.
`default_nettype none

module circular_deque_core #(
   parameter int SLOTS = cdq_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [cdq_pkg::DATA_W-1:0]    req_tdata,   // push_value
   input  wire logic [cdq_pkg::KIND_W-1:0]    req_tuser,   // req_type
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [cdq_pkg::DATA_W-1:0]    rsp_tdata,   // read_value
   output logic      [cdq_pkg::STATUS_W-1:0]  rsp_tuser    // status
);

   cdq_pkg::cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cdq_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/core/cdq_checker.sv =====
// port-level checks for the circular deque, bound to the top level
`default_nettype none
`include "circular_deque_core_defines.svh"

module cdq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [cdq_pkg::DATA_W-1:0]    rsp_tdata,
   input wire logic [cdq_pkg::STATUS_W-1:0]  rsp_tuser
);

   logic req_beat;
   logic rsp_stall;
   logic refused;

   assign req_beat  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign refused   = (rsp_tuser == cdq_pkg::STATUS_FULL)
                      || (rsp_tuser == cdq_pkg::STATUS_EMPTY);

   // stalled response holds
   `CDQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // no response in the cycle after a request beat
   `CDQ_ASSERT_NEXT(a_req_latency, req_beat, !rsp_tvalid)
   // one request in flight
   `CDQ_ASSERT_NOW(a_one_in_flight, rsp_tvalid, !req_tready)
   // status code of a valid response is always a defined one
   `CDQ_ASSERT_NOW(a_status_code, rsp_tvalid, (rsp_tuser == cdq_pkg::STATUS_OK) || refused)
   // refused beat carries zero data
   `CDQ_ASSERT_NOW(a_refused_zero, rsp_tvalid && refused, rsp_tdata == '0)

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);

`default_nettype wire
